### rtl/core/wmrs_pkg.sv
// Shared types, codes and helpers of the wavelet matrix rank/select block.
package wmrs_pkg;

   localparam int SYM_W = 16;
   localparam int LVL_W = 5;
   localparam int NUM_LEVELS = 16;

   localparam logic [2:0] CMD_LOAD   = 3'd0;
   localparam logic [2:0] CMD_BUILD  = 3'd1;
   localparam logic [2:0] CMD_ACCESS = 3'd2;
   localparam logic [2:0] CMD_RANK   = 3'd3;
   localparam logic [2:0] CMD_SELECT = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_RANGE     = 3'd1;
   localparam logic [2:0] ST_NO_OCC    = 3'd2;
   localparam logic [2:0] ST_NOT_BUILT = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_LOAD, S_BUILD,
      S_CP_CHK, S_CP_RD, S_CP_WR, S_LVL_CHK,
      S_P1_CHK, S_P1_RD, S_P1_WR, S_P2_CHK, S_P2_RD, S_P2_WR,
      S_SC_CHK, S_SC_RD, S_SC_WR,
      S_NR_CHK, S_NR_RD, S_NR_USE, S_NR_UPD, S_NR_POST,
      S_SEL_CHK, S_FD_CHK, S_FD_RD, S_FD_USE, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_DECODE, OP_LOAD, OP_BUILD,
      OP_CP_CHK, OP_CP_WR, OP_LVL_CHK,
      OP_P1_CHK, OP_P1_WR, OP_P2_CHK, OP_P2_WR,
      OP_SC_CHK, OP_SC_WR,
      OP_NR_USE, OP_NR_UPD, OP_NR_POST,
      OP_SEL_CHK, OP_FD_CHK, OP_FD_USE, OP_EMIT
   } dp_op_type;

   typedef enum logic [1:0] {
      RT_DONE, RT_LOAD, RT_BUILD, RT_NARROW
   } route_type;

   typedef struct packed {
      route_type route;
      logic      is_select;
      logic      k_at_n;
      logic      scan_end;
      logic      lvl_at_lc;
      logic      lvl_zero;
      logic      sel_bad;
      logic      found;
      logic      out_free;
   } dp_stat_type;

   function automatic logic [LVL_W-1:0] bit_len(input logic [SYM_W-1:0] v);
      logic [LVL_W-1:0] n;
      n = '0;
      for (int i = 0; i < SYM_W; i++) begin
         if (v[i]) n = LVL_W'(i + 1);
      end
      return n;
   endfunction

endpackage

### rtl/core/wavelet_matrix_rank_select.sv
// Access, rank and select scan each level's bitmap over a position range; select then searches
// back down the levels; build copies the store, then per level partitions and copies back.
// Store and bitmap reads are registered.
// One item is in work at a time; a new item is taken while the previous result waits.
// Reset (synchronous, active high) empties the store, clears the level zero counts,
// level count, maximum and built flag; no clearing pass is needed.
module wavelet_matrix_rank_select #(
   parameter int MAX_SYMBOLS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [15:0] symbol_value, [26:16] position, rest zero
   input  logic [2:0]  req_tuser,  // [2:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [15:0] result_value
   output logic [2:0]  rsp_tuser   // [2:0] status
);
   import wmrs_pkg::*;

   dp_op_type   op;
   dp_stat_type stat;

   wmrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .op         (op)
   );

   wmrs_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .stat         (stat),
      .command      (req_tuser),
      .symbol_value (req_tdata[15:0]),
      .position     (req_tdata[26:16]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .result_value (rsp_tdata),
      .status       (rsp_tuser)
   );

endmodule

### rtl/core/wmrs_ctrl.sv
// Sequencer of the wavelet matrix block: steps build passes, level scans and searches.
module wmrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  wmrs_pkg::dp_stat_type stat,
   output wmrs_pkg::dp_op_type  op
);
   import wmrs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            unique case (stat.route)
               RT_LOAD:   state_in = S_LOAD;
               RT_BUILD:  state_in = S_BUILD;
               RT_NARROW: state_in = S_NR_CHK;
               default:   state_in = S_DONE;
            endcase
         end
         S_LOAD:    state_in = S_DONE;
         S_BUILD:   state_in = S_CP_CHK;
         S_CP_CHK:  state_in = stat.k_at_n ? S_LVL_CHK : S_CP_RD;
         S_CP_RD:   state_in = S_CP_WR;
         S_CP_WR:   state_in = S_CP_CHK;
         S_LVL_CHK: state_in = stat.lvl_at_lc ? S_DONE : S_P1_CHK;
         S_P1_CHK:  state_in = stat.k_at_n ? S_P2_CHK : S_P1_RD;
         S_P1_RD:   state_in = S_P1_WR;
         S_P1_WR:   state_in = S_P1_CHK;
         S_P2_CHK:  state_in = stat.k_at_n ? S_SC_CHK : S_P2_RD;
         S_P2_RD:   state_in = S_P2_WR;
         S_P2_WR:   state_in = S_P2_CHK;
         S_SC_CHK:  state_in = stat.k_at_n ? S_LVL_CHK : S_SC_RD;
         S_SC_RD:   state_in = S_SC_WR;
         S_SC_WR:   state_in = S_SC_CHK;
         S_NR_CHK:  state_in = stat.lvl_at_lc ? S_NR_POST : S_NR_RD;
         S_NR_RD:   state_in = S_NR_USE;
         S_NR_USE:  state_in = stat.scan_end ? S_NR_UPD : S_NR_RD;
         S_NR_UPD:  state_in = S_NR_CHK;
         S_NR_POST: state_in = stat.is_select ? S_SEL_CHK : S_DONE;
         S_SEL_CHK: state_in = stat.sel_bad ? S_DONE : S_FD_CHK;
         S_FD_CHK:  state_in = stat.lvl_zero ? S_DONE : S_FD_RD;
         S_FD_RD:   state_in = S_FD_USE;
         S_FD_USE:  state_in = stat.found ? S_FD_CHK : S_FD_RD;
         S_DONE:    if (stat.out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op         = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) op = OP_ACCEPT;
         end
         S_DECODE:  op = OP_DECODE;
         S_LOAD:    op = OP_LOAD;
         S_BUILD:   op = OP_BUILD;
         S_CP_CHK:  op = OP_CP_CHK;
         S_CP_WR:   op = OP_CP_WR;
         S_LVL_CHK: op = OP_LVL_CHK;
         S_P1_CHK:  op = OP_P1_CHK;
         S_P1_WR:   op = OP_P1_WR;
         S_P2_CHK:  op = OP_P2_CHK;
         S_P2_WR:   op = OP_P2_WR;
         S_SC_CHK:  op = OP_SC_CHK;
         S_SC_WR:   op = OP_SC_WR;
         S_NR_USE:  op = OP_NR_USE;
         S_NR_UPD:  op = OP_NR_UPD;
         S_NR_POST: op = OP_NR_POST;
         S_SEL_CHK: op = OP_SEL_CHK;
         S_FD_CHK:  op = OP_FD_CHK;
         S_FD_USE:  op = OP_FD_USE;
         S_DONE:    if (stat.out_free) op = OP_EMIT;
         default:   op = OP_NONE;
      endcase
   end

endmodule

### rtl/core/wmrs_datapath.sv
// Stores, level bitmaps, counters and result register of the wavelet matrix block.
module wmrs_datapath #(
   parameter int MAX_SYMBOLS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wmrs_pkg::dp_op_type   op,
   output wmrs_pkg::dp_stat_type stat,
   input  logic [2:0]            command,
   input  logic [15:0]           symbol_value,
   input  logic [10:0]           position,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           result_value,
   output logic [2:0]            status
);
   import wmrs_pkg::*;

   localparam int IW  = $clog2(MAX_SYMBOLS);
   localparam int NW  = $clog2(MAX_SYMBOLS + 1);
   localparam int CW  = (NW > 11) ? NW : 11;
   localparam int BAW = 4 + IW;

   // stores
   logic [SYM_W-1:0] sym_mem  [0:MAX_SYMBOLS-1];
   logic [SYM_W-1:0] pbuf_mem [0:MAX_SYMBOLS-1];
   logic [SYM_W-1:0] sbuf_mem [0:MAX_SYMBOLS-1];
   logic             bit_mem  [0:(NUM_LEVELS << IW)-1];
   logic [SYM_W-1:0] sym_rd_ff, pbuf_rd_ff, sbuf_rd_ff;
   logic             bit_rd_ff;

   // control and working registers
   logic [2:0]       cmd_ff;
   logic [SYM_W-1:0] sym_ff, max_ff;
   logic [CW-1:0]    pos_ff, n_ff, k_ff, cnt_ff, wr_ff;
   logic [CW-1:0]    s_ff, e_ff, rs_ff, re_ff, p_ff;
   logic [CW-1:0]    zeros_ff [0:NUM_LEVELS-1];
   logic [LVL_W-1:0] lc_ff, lvl_ff;
   logic             built_ff, b_ff, sel_phase_ff;
   logic [SYM_W-1:0] res_ff;
   logic [2:0]       st_ff;
   logic             rsp_valid_ff;
   logic [SYM_W-1:0] rsp_data_ff;
   logic [2:0]       rsp_st_ff;

   logic [LVL_W-1:0] lidx, bidx;
   logic [CW-1:0]    zcur;
   logic             sym_bit, build_bit, wide_sym, fd_match;
   logic [BAW-1:0]   bit_addr;
   logic             pbuf_we, sbuf_we;
   logic [SYM_W-1:0] pbuf_wd;
   route_type        route;
   logic [2:0]       dec_st;

   assign lidx      = sel_phase_ff ? (lvl_ff - LVL_W'(1)) : lvl_ff;
   assign bidx      = lc_ff - LVL_W'(1) - lidx;
   assign zcur      = zeros_ff[lidx[3:0]];
   assign sym_bit   = sym_ff[bidx[3:0]];
   assign build_bit = pbuf_rd_ff[bidx[3:0]];
   assign wide_sym  = (sym_ff >> lc_ff) != '0;
   assign fd_match  = (bit_rd_ff == b_ff) && (cnt_ff == e_ff);
   assign bit_addr  = {lidx[3:0], k_ff[IW-1:0]};

   // command screening
   always_comb begin
      route  = RT_DONE;
      dec_st = ST_OK;
      unique case (cmd_ff) inside
         CMD_LOAD: begin
            if (n_ff == CW'(MAX_SYMBOLS)) dec_st = ST_FULL;
            else                          route  = RT_LOAD;
         end
         CMD_BUILD: route = RT_BUILD;
         CMD_ACCESS, CMD_RANK: begin
            if (!built_ff)          dec_st = ST_NOT_BUILT;
            else if (pos_ff >= n_ff) dec_st = ST_RANGE;
            else if (cmd_ff == CMD_ACCESS || !wide_sym) route = RT_NARROW;
         end
         CMD_SELECT: begin
            if (!built_ff)    dec_st = ST_NOT_BUILT;
            else if (wide_sym) dec_st = ST_NO_OCC;
            else               route  = RT_NARROW;
         end
         default: route = RT_DONE;
      endcase
   end

   always_comb begin
      stat.route     = route;
      stat.is_select = (cmd_ff == CMD_SELECT);
      stat.k_at_n    = (k_ff == n_ff);
      stat.scan_end  = (k_ff == e_ff);
      stat.lvl_at_lc = (lvl_ff == lc_ff);
      stat.lvl_zero  = (lvl_ff == '0);
      stat.sel_bad   = (pos_ff == '0) || (pos_ff > (e_ff - s_ff));
      stat.found     = fd_match || (k_ff == n_ff - CW'(1));
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // memory ports
   assign pbuf_we = (op == OP_CP_WR) || (op == OP_SC_WR);
   assign pbuf_wd = (op == OP_CP_WR) ? sym_rd_ff : sbuf_rd_ff;
   assign sbuf_we = ((op == OP_P1_WR) && !build_bit) || ((op == OP_P2_WR) && build_bit);

   always_ff @(posedge clock) begin
      if (op == OP_LOAD) sym_mem[n_ff[IW-1:0]] <= sym_ff;
      sym_rd_ff <= sym_mem[k_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pbuf_we) pbuf_mem[k_ff[IW-1:0]] <= pbuf_wd;
      pbuf_rd_ff <= pbuf_mem[k_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sbuf_we) sbuf_mem[wr_ff[IW-1:0]] <= pbuf_rd_ff;
      sbuf_rd_ff <= sbuf_mem[k_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (op == OP_P1_WR) bit_mem[bit_addr] <= build_bit;
      bit_rd_ff <= bit_mem[bit_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         max_ff       <= '0;
         lc_ff        <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) zeros_ff[i] <= '0;
      end else begin
         if (op == OP_EMIT)       rsp_valid_ff <= 1'b1;
         else if (rsp_tready)     rsp_valid_ff <= 1'b0;
         case (op)
            OP_LOAD: begin
               n_ff     <= n_ff + CW'(1);
               built_ff <= 1'b0;
               if (sym_ff > max_ff) max_ff <= sym_ff;
            end
            OP_BUILD:   lc_ff <= bit_len(max_ff);
            OP_LVL_CHK: if (lvl_ff == lc_ff) built_ff <= 1'b1;
            OP_P1_CHK:  if (k_ff == n_ff) zeros_ff[lidx[3:0]] <= wr_ff;
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (op) inside
         OP_ACCEPT: begin
            cmd_ff <= command;
            sym_ff <= symbol_value;
            pos_ff <= CW'(position);
         end
         OP_DECODE: begin
            st_ff        <= dec_st;
            res_ff       <= '0;
            lvl_ff       <= '0;
            k_ff         <= '0;
            cnt_ff       <= '0;
            sel_phase_ff <= 1'b0;
            case (cmd_ff)
               CMD_ACCESS: begin
                  s_ff <= pos_ff;
                  e_ff <= pos_ff;
               end
               CMD_RANK: begin
                  s_ff <= '0;
                  e_ff <= pos_ff + CW'(1);
               end
               default: begin
                  s_ff <= '0;
                  e_ff <= n_ff;
               end
            endcase
         end
         OP_BUILD: begin
            k_ff   <= '0;
            lvl_ff <= '0;
         end
         OP_CP_WR, OP_SC_WR: k_ff <= k_ff + CW'(1);
         OP_LVL_CHK: begin
            k_ff  <= '0;
            wr_ff <= '0;
         end
         OP_P1_CHK, OP_P2_CHK: if (k_ff == n_ff) k_ff <= '0;
         OP_P1_WR: begin
            if (!build_bit) wr_ff <= wr_ff + CW'(1);
            k_ff <= k_ff + CW'(1);
         end
         OP_P2_WR: begin
            if (build_bit) wr_ff <= wr_ff + CW'(1);
            k_ff <= k_ff + CW'(1);
         end
         OP_SC_CHK: if (k_ff == n_ff) lvl_ff <= lvl_ff + LVL_W'(1);
         OP_NR_USE: begin
            if (k_ff == s_ff) begin
               rs_ff <= cnt_ff;
               b_ff  <= bit_rd_ff;
            end
            if (k_ff == e_ff) begin
               re_ff <= cnt_ff;
            end else begin
               cnt_ff <= cnt_ff + CW'(bit_rd_ff);
               k_ff   <= k_ff + CW'(1);
            end
         end
         OP_NR_UPD: begin
            if (cmd_ff == CMD_ACCESS) begin
               // follow the single position down one level
               if (b_ff) begin
                  s_ff <= zcur + rs_ff;
                  e_ff <= zcur + rs_ff;
                  res_ff[bidx[3:0]] <= 1'b1;
               end else begin
                  s_ff <= s_ff - rs_ff;
                  e_ff <= s_ff - rs_ff;
               end
            end else if (sym_bit) begin
               s_ff <= zcur + rs_ff;
               e_ff <= zcur + re_ff;
            end else begin
               s_ff <= s_ff - rs_ff;
               e_ff <= e_ff - re_ff;
            end
            lvl_ff <= lvl_ff + LVL_W'(1);
            k_ff   <= '0;
            cnt_ff <= '0;
         end
         OP_NR_POST: if (cmd_ff == CMD_RANK) res_ff <= SYM_W'(e_ff - s_ff);
         OP_SEL_CHK: begin
            if (stat.sel_bad) begin
               st_ff <= ST_NO_OCC;
            end else begin
               p_ff         <= s_ff + pos_ff - CW'(1);
               lvl_ff       <= lc_ff;
               sel_phase_ff <= 1'b1;
            end
         end
         OP_FD_CHK: begin
            if (lvl_ff != '0) begin
               // e holds the occurrence index sought in this level
               e_ff   <= sym_bit ? (p_ff - zcur) : p_ff;
               b_ff   <= sym_bit;
               k_ff   <= '0;
               cnt_ff <= '0;
            end else begin
               res_ff <= SYM_W'(p_ff);
            end
         end
         OP_FD_USE: begin
            if (stat.found) begin
               p_ff   <= fd_match ? k_ff : '0;
               lvl_ff <= lvl_ff - LVL_W'(1);
            end else begin
               if (bit_rd_ff == b_ff) cnt_ff <= cnt_ff + CW'(1);
               k_ff <= k_ff + CW'(1);
            end
         end
         OP_EMIT: begin
            rsp_data_ff <= res_ff;
            rsp_st_ff   <= st_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign result_value = rsp_data_ff;
   assign status       = rsp_st_ff;

endmodule

### rtl/core/wmrs_checker.sv
// Port-level checks of the wavelet matrix block, bound to the top level.
module wmrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import wmrs_pkg::*;

   // a waiting result must not change under back-pressure
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0)
      else $error("error result carries data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_RANGE || rsp_tuser == ST_NO_OCC
                     || rsp_tuser == ST_NOT_BUILT || rsp_tuser == ST_FULL)
      else $error("undefined status");

   // a result never appears directly after an input transfer taken while no result waited
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result before work done");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind wavelet_matrix_rank_select wmrs_checker u_wmrs_checker (.*);

### tb/tb_wavelet_matrix_rank_select.sv
// Self-checking testbench for the wavelet matrix rank/select index.
module tb_wavelet_matrix_rank_select;
   timeunit 1ns;
   timeprecision 1ps;
   import wmrs_pkg::*;

   localparam int MAX_SYM = 1024;
   localparam int STALL_LIMIT = 1000000;
   localparam logic [2:0] CMD_RSVD_A = 3'd5;
   localparam logic [2:0] CMD_RSVD_B = 3'd6;
   localparam logic [2:0] CMD_RSVD_C = 3'd7;

   typedef struct {
      logic [2:0]  cmd;
      logic [15:0] sym;
      logic [10:0] pos;
      int          gap;
      bit          drain;
   } wm_item_type;

   typedef struct {
      logic [15:0] value;
      logic [2:0]  status;
   } wm_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // [15:0] symbol_value, [26:16] position
   logic [2:0]  req_tuser = '0;  // [2:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // [15:0] result_value
   logic [2:0]  rsp_tuser;       // [2:0] status

   wavelet_matrix_rank_select dut (.*);

   always #4 clock = ~clock;

   // predictor state
   int unsigned wm_store [MAX_SYM];
   int unsigned wm_part  [MAX_SYM];
   int unsigned wm_tmp   [MAX_SYM];
   bit          wm_bits  [NUM_LEVELS][MAX_SYM];
   int unsigned wm_zeros [NUM_LEVELS];
   int unsigned wm_n = 0, wm_lc = 0, wm_max = 0;
   bit          wm_built = 1'b0;

   wm_item_type   send_q [$];
   wm_answer_type answer_q [$];
   int items_sent = 0, results_seen = 0, mismatches = 0;
   int idle_cnt = 0, hold = 0, quiet = 0;
   bit long_hold_done = 1'b0;

   function automatic void add_item(wm_item_type x);
      send_q = {send_q, x};
   endfunction

   function automatic int unsigned level_bit(int unsigned v, int unsigned l);
      return (v >> (wm_lc - 1 - l)) & 1;
   endfunction

   function automatic int unsigned ones_before(int unsigned l, int unsigned e);
      int unsigned c = 0;
      for (int unsigned i = 0; i < e && i < wm_n; i++) c += wm_bits[l][i];
      return c;
   endfunction

   function automatic int unsigned nth_of(int unsigned l, bit b, int unsigned j);
      int unsigned c = 0;
      for (int unsigned i = 0; i < wm_n; i++) begin
         if (wm_bits[l][i] == b) begin
            if (c == j) return i;
            c++;
         end
      end
      return 0;
   endfunction

   function automatic void rebuild_levels();
      int unsigned v = wm_max, nz, no;
      wm_lc = 0;
      while (v != 0) begin
         wm_lc++;
         v >>= 1;
      end
      for (int i = 0; i < wm_n; i++) wm_part[i] = wm_store[i];
      for (int unsigned l = 0; l < wm_lc; l++) begin
         nz = 0;
         for (int k = 0; k < wm_n; k++) begin
            wm_bits[l][k] = level_bit(wm_part[k], l);
            if (!wm_bits[l][k]) wm_tmp[nz++] = wm_part[k];
         end
         no = nz;
         for (int k = 0; k < wm_n; k++) if (wm_bits[l][k]) wm_tmp[no++] = wm_part[k];
         wm_zeros[l] = nz;
         for (int k = 0; k < wm_n; k++) wm_part[k] = wm_tmp[k];
      end
      wm_built = 1'b1;
   endfunction

   function automatic void narrow_range(int unsigned sym, inout int unsigned s,
                                        inout int unsigned e);
      int unsigned rs, re;
      for (int unsigned l = 0; l < wm_lc; l++) begin
         rs = ones_before(l, s);
         re = ones_before(l, e);
         if (level_bit(sym, l)) begin
            s = wm_zeros[l] + rs;
            e = wm_zeros[l] + re;
         end else begin
            s -= rs;
            e -= re;
         end
      end
   endfunction

   function automatic wm_answer_type wm_answer(wm_item_type it);
      wm_answer_type a;
      int unsigned sym = it.sym, pos = it.pos, p, s, e, l;
      a.value = '0;
      a.status = ST_OK;
      if (it.cmd == CMD_LOAD) begin
         if (wm_n >= MAX_SYM) a.status = ST_FULL;
         else begin
            wm_store[wm_n++] = sym;
            if (sym > wm_max) wm_max = sym;
            wm_built = 1'b0;
         end
      end else if (it.cmd == CMD_BUILD) begin
         rebuild_levels();
      end else if (it.cmd == CMD_ACCESS || it.cmd == CMD_RANK || it.cmd == CMD_SELECT) begin
         if (!wm_built) a.status = ST_NOT_BUILT;
         else if (it.cmd == CMD_ACCESS) begin
            if (pos >= wm_n) a.status = ST_RANGE;
            else begin
               p = pos;
               for (l = 0; l < wm_lc; l++) begin
                  if (wm_bits[l][p]) begin
                     p = wm_zeros[l] + ones_before(l, p);
                     a.value[wm_lc - 1 - l] = 1'b1;
                  end else p -= ones_before(l, p);
               end
            end
         end else if (it.cmd == CMD_RANK) begin
            if (pos >= wm_n) a.status = ST_RANGE;
            else if ((sym >> wm_lc) == 0) begin
               s = 0;
               e = pos + 1;
               narrow_range(sym, s, e);
               a.value = 16'(e - s);
            end
         end else begin
            s = 0;
            e = wm_n;
            if ((sym >> wm_lc) != 0) a.status = ST_NO_OCC;
            else begin
               narrow_range(sym, s, e);
               if (pos == 0 || pos > e - s) a.status = ST_NO_OCC;
               else begin
                  p = s + pos - 1;
                  l = wm_lc;
                  while (l > 0) begin
                     l--;
                     if (level_bit(sym, l)) p = nth_of(l, 1'b1, p - wm_zeros[l]);
                     else p = nth_of(l, 1'b0, p);
                  end
                  a.value = 16'(p);
               end
            end
         end
      end
      return a;
   endfunction

   // driver
   always @(posedge clock) begin
      wm_item_type cur;
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_cnt <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            cur.cmd = req_tuser;
            cur.sym = req_tdata[15:0];
            cur.pos = req_tdata[26:16];
            answer_q = {answer_q, wm_answer(cur)};
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_q.size() == 0) req_tvalid <= 1'b0;
            else if (send_q[0].drain && answer_q.size() != 0) req_tvalid <= 1'b0;
            else if (idle_cnt < send_q[0].gap) begin
               idle_cnt <= idle_cnt + 1;
               req_tvalid <= 1'b0;
            end else begin
               cur = send_q.pop_front();
               req_tuser <= cur.cmd;
               req_tdata <= {5'b0, cur.pos, cur.sym};
               req_tvalid <= 1'b1;
               idle_cnt <= 0;
            end
         end
      end
   end

   // monitor and result checking
   always @(posedge clock) begin
      wm_answer_type want;
      if (reset) rsp_tready <= 1'b0;
      else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (answer_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer: value %0d status %0d", rsp_tdata, rsp_tuser);
            end else begin
               want = answer_q.pop_front();
               if (rsp_tdata !== want.value || rsp_tuser !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected value %0d status %0d, got %0d %0d",
                              results_seen, want.value, want.status, rsp_tdata, rsp_tuser);
               end
            end
         end
         // one long hold-off so the input side backs up
         if (!long_hold_done && results_seen == 120) begin
            long_hold_done <= 1'b1;
            hold <= 400;
            rsp_tready <= 1'b0;
         end else if (hold > 0) begin
            hold <= hold - 1;
            rsp_tready <= 1'b0;
         end else if (results_seen >= 300 && results_seen < 400) rsp_tready <= 1'b1;
         else if ($urandom_range(0, 99) < 25) begin
            hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > STALL_LIMIT) begin
         $display("wavelet_matrix_rank_select: mismatch");
         $finish;
      end
   end

   function automatic int pick_gap(bit busy);
      int r = $urandom_range(0, 99);
      if (busy) return 0;
      if (r < 55) return 0;
      if (r < 80) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int gen_n = 0, loads, queries, r;
      bit busy;
      wm_item_type it;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: before build, empty build, reserved commands
      add_item('{CMD_ACCESS, 16'd0, 11'd0, 0, 0});
      add_item('{CMD_RANK, 16'd3, 11'd0, 0, 0});
      add_item('{CMD_SELECT, 16'd3, 11'd1, 0, 0});
      add_item('{CMD_BUILD, 16'd0, 11'd0, 0, 0});
      add_item('{CMD_ACCESS, 16'd0, 11'd0, 0, 0});
      add_item('{CMD_RANK, 16'd0, 11'd0, 0, 0});
      add_item('{CMD_SELECT, 16'd0, 11'd1, 0, 0});
      add_item('{CMD_RSVD_A, 16'hFFFF, 11'h7FF, 0, 0});
      add_item('{CMD_RSVD_B, 16'd0, 11'd0, 1, 0});
      add_item('{CMD_RSVD_C, 16'h5A5A, 11'h2AA, 0, 0});
      // small sequence with repeats
      add_item('{CMD_LOAD, 16'd0, 11'd0, 0, 0});
      add_item('{CMD_LOAD, 16'd13, 11'h7FF, 0, 0});
      add_item('{CMD_LOAD, 16'd5, 11'd0, 2, 0});
      add_item('{CMD_LOAD, 16'd5, 11'd0, 0, 0});
      add_item('{CMD_LOAD, 16'd1, 11'd0, 0, 0});
      gen_n = 5;
      add_item('{CMD_BUILD, 16'd0, 11'd0, 0, 0});
      add_item('{CMD_ACCESS, 16'd0, 11'd1, 0, 0});
      add_item('{CMD_ACCESS, 16'd0, 11'd5, 0, 0});
      add_item('{CMD_ACCESS, 16'd0, 11'h7FF, 0, 0});
      add_item('{CMD_RANK, 16'd5, 11'd4, 0, 0});
      add_item('{CMD_RANK, 16'hFFFF, 11'd4, 0, 0});
      add_item('{CMD_SELECT, 16'd5, 11'd2, 0, 0});
      add_item('{CMD_SELECT, 16'd5, 11'd0, 0, 0});
      add_item('{CMD_SELECT, 16'd5, 11'd3, 0, 0});
      add_item('{CMD_SELECT, 16'h8000, 11'd1, 0, 0});
      // load after build leaves the index stale
      add_item('{CMD_LOAD, 16'd31, 11'd0, 0, 0});
      add_item('{CMD_RANK, 16'd5, 11'd1, 0, 0});
      gen_n++;

      // random: bursts of loads, usually a build, then queries
      while (send_q.size() + 8 < 850) begin
         busy = (send_q.size() > 150 && send_q.size() < 260);
         loads = $urandom_range(0, 4);
         repeat (loads) begin
            it = '{CMD_LOAD, 16'($urandom_range(0, 31)), 11'($urandom), pick_gap(busy), 0};
            add_item(it);
            gen_n++;
         end
         if ($urandom_range(0, 9) != 0)
            add_item('{CMD_BUILD, 16'($urandom), 11'($urandom), pick_gap(busy),
                       $urandom_range(0, 29) == 0});
         queries = $urandom_range(3, 12);
         repeat (queries) begin
            r = $urandom_range(0, 99);
            it.gap = pick_gap(busy);
            it.drain = 1'b0;
            it.sym = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 33));
            if (r < 3) begin
               it.cmd = 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
               it.pos = 11'($urandom);
            end else if (r < 35) begin
               it.cmd = CMD_ACCESS;
               it.pos = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, gen_n));
            end else if (r < 68) begin
               it.cmd = CMD_RANK;
               it.pos = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, gen_n));
            end else begin
               it.cmd = CMD_SELECT;
               it.pos = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 8));
            end
            add_item(it);
         end
      end

      // widest symbol last after a full drain, then a sixteen-level index
      add_item('{CMD_LOAD, 16'hFFFF, 11'd0, 0, 1});
      gen_n++;
      add_item('{CMD_BUILD, 16'd0, 11'd0, 0, 0});
      add_item('{CMD_ACCESS, 16'd0, 11'(gen_n - 1), 0, 0});
      add_item('{CMD_ACCESS, 16'd0, 11'd0, 0, 0});
      add_item('{CMD_ACCESS, 16'd0, 11'(gen_n), 0, 0});
      add_item('{CMD_RANK, 16'hFFFF, 11'(gen_n - 1), 0, 0});
      add_item('{CMD_SELECT, 16'hFFFF, 11'd1, 0, 0});
      add_item('{CMD_SELECT, 16'hFFFF, 11'd2, 0, 0});

      wait (send_q.size() == 0 && !req_tvalid && answer_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("sent %0d items (loads, rebuilds, queries on stale and fresh indexes, %s",
               items_sent, "reserved codes, a sixteen-level index)");
      $display("checked %0d results under random stalls and one long hold-off", results_seen);
      if (mismatches == 0 && answer_q.size() == 0)
         $display("wavelet_matrix_rank_select: match");
      else
         $display("wavelet_matrix_rank_select: mismatch");
      $finish;
   end
endmodule
